>>> src/btr_pkg.sv
// btr_pkg: shared types, kind codes and fault codes of the branch target resolver.
// No dependencies; used by btr_resolve and branch_target_resolver_top.
package btr_pkg;

   // Instruction variant codes
   localparam logic [4:0] KIND_BRA_DISP   = 5'd0;
   localparam logic [4:0] KIND_BSR_DISP   = 5'd1;
   localparam logic [4:0] KIND_BT_DISP    = 5'd2;
   localparam logic [4:0] KIND_BF_DISP    = 5'd3;
   localparam logic [4:0] KIND_BSR4_DISP  = 5'd4;
   localparam logic [4:0] KIND_BRA_PCREG  = 5'd5;
   localparam logic [4:0] KIND_BSR_PCREG  = 5'd6;
   localparam logic [4:0] KIND_BRA_PCDR   = 5'd7;
   localparam logic [4:0] KIND_BSR_PCDR   = 5'd8;
   localparam logic [4:0] KIND_BT_PCDR    = 5'd9;
   localparam logic [4:0] KIND_BF_PCDR    = 5'd10;
   localparam logic [4:0] KIND_BRA_PCDR4  = 5'd11;
   localparam logic [4:0] KIND_BSR_PCDR4  = 5'd12;
   localparam logic [4:0] KIND_BT_PCDR4   = 5'd13;
   localparam logic [4:0] KIND_BF_PCDR4   = 5'd14;
   localparam logic [4:0] KIND_BRA_REG    = 5'd15;
   localparam logic [4:0] KIND_BSR_REG    = 5'd16;
   localparam logic [4:0] KIND_BT_REG     = 5'd17;
   localparam logic [4:0] KIND_BF_REG     = 5'd18;
   localparam logic [4:0] KIND_RTS        = 5'd19;
   localparam logic [4:0] KIND_RET        = 5'd20;
   localparam logic [4:0] KIND_BREAK      = 5'd21;
   localparam logic [4:0] KIND_SLEEP      = 5'd22;
   localparam logic [4:0] KIND_INVOP      = 5'd23;

   // Branch condition classes
   localparam logic [1:0] OP_BRA = 2'd0;
   localparam logic [1:0] OP_BSR = 2'd1;
   localparam logic [1:0] OP_BT  = 2'd2;
   localparam logic [1:0] OP_BF  = 2'd3;

   // Fault codes
   localparam logic [1:0] FAULT_NONE  = 2'd0;
   localparam logic [1:0] FAULT_INVOP = 2'd1;
   localparam logic [1:0] FAULT_BREAK = 2'd2;
   localparam logic [1:0] FAULT_SLEEP = 2'd3;

   // Stack return pops one 64-bit word
   localparam logic [63:0] SP_POP_BYTES = 64'd8;
   // Short-form BSR links past a 4-byte instruction
   localparam logic [63:0] BSR4_LINK_BYTES = 64'd4;

   typedef struct packed {
      logic [4:0]         kind;
      logic [63:0]        instr_pc;
      logic [63:0]        next_pc;
      logic signed [23:0] displacement;
      logic [63:0]        reg_operand;
      logic [63:0]        dr_value;
      logic [63:0]        lr_value;
      logic [63:0]        sp_value;
      logic [63:0]        stack_word;
      logic               t_flag;
   } req_type;

   typedef struct packed {
      logic        taken;
      logic [63:0] target_pc;
      logic        lr_write;
      logic [63:0] lr_new;
      logic        sp_write;
      logic [63:0] sp_new;
      logic [1:0]  fault;
   } rsp_type;

endpackage

>>> src/btr_resolve.sv
// btr_resolve: combinational resolution of one control-flow instruction.
// Depends on btr_pkg for the request/response types and codes.
module btr_resolve
   import btr_pkg::*;
(
   input  req_type req,
   output rsp_type rsp
);

   logic [63:0] disp_ext;
   logic [63:0] disp_x2;
   logic [63:0] reg_x2;
   logic [63:0] dr_x2;
   logic [63:0] dr_x32;
   logic [63:0] dest;
   logic [1:0]  op;
   logic        has_op;
   logic        go;

   // Scaled operands, all modulo 2^64
   assign disp_ext = {{40{req.displacement[23]}}, req.displacement};
   assign disp_x2  = {disp_ext[62:0], 1'b0};
   assign reg_x2   = {req.reg_operand[62:0], 1'b0};
   assign dr_x2    = {req.dr_value[62:0], 1'b0};
   assign dr_x32   = {req.dr_value[58:0], 5'b0};

   // Decode addressing form and condition class
   always_comb begin
      dest   = 64'd0;
      op     = OP_BRA;
      has_op = 1'b0;
      case (req.kind)
         KIND_BRA_DISP, KIND_BSR_DISP, KIND_BT_DISP, KIND_BF_DISP: begin
            dest   = req.next_pc + disp_x2;
            op     = req.kind[1:0];
            has_op = 1'b1;
         end
         KIND_BSR4_DISP: begin
            dest   = req.next_pc + disp_x2;
            op     = OP_BSR;
            has_op = 1'b1;
         end
         KIND_BRA_PCREG: begin
            dest   = req.next_pc + reg_x2;
            op     = OP_BRA;
            has_op = 1'b1;
         end
         KIND_BSR_PCREG: begin
            dest   = req.next_pc + reg_x2;
            op     = OP_BSR;
            has_op = 1'b1;
         end
         KIND_BRA_PCDR: begin
            dest   = req.next_pc + dr_x2;
            op     = OP_BRA;
            has_op = 1'b1;
         end
         KIND_BSR_PCDR: begin
            dest   = req.next_pc + dr_x2;
            op     = OP_BSR;
            has_op = 1'b1;
         end
         KIND_BT_PCDR: begin
            dest   = req.next_pc + dr_x2;
            op     = OP_BT;
            has_op = 1'b1;
         end
         KIND_BF_PCDR: begin
            dest   = req.next_pc + dr_x2;
            op     = OP_BF;
            has_op = 1'b1;
         end
         KIND_BRA_PCDR4: begin
            dest   = req.next_pc + dr_x32 + disp_x2;
            op     = OP_BRA;
            has_op = 1'b1;
         end
         KIND_BSR_PCDR4: begin
            dest   = req.next_pc + dr_x32 + disp_x2;
            op     = OP_BSR;
            has_op = 1'b1;
         end
         KIND_BT_PCDR4: begin
            dest   = req.next_pc + dr_x32 + disp_x2;
            op     = OP_BT;
            has_op = 1'b1;
         end
         KIND_BF_PCDR4: begin
            dest   = req.next_pc + dr_x32 + disp_x2;
            op     = OP_BF;
            has_op = 1'b1;
         end
         KIND_BRA_REG: begin
            dest   = req.reg_operand;
            op     = OP_BRA;
            has_op = 1'b1;
         end
         KIND_BSR_REG: begin
            dest   = req.reg_operand;
            op     = OP_BSR;
            has_op = 1'b1;
         end
         KIND_BT_REG: begin
            dest   = req.reg_operand;
            op     = OP_BT;
            has_op = 1'b1;
         end
         KIND_BF_REG: begin
            dest   = req.reg_operand;
            op     = OP_BF;
            has_op = 1'b1;
         end
         default: begin
            dest   = 64'd0;
            op     = OP_BRA;
            has_op = 1'b0;
         end
      endcase
   end

   // Condition evaluation
   always_comb begin
      case (op)
         OP_BRA:  go = 1'b1;
         OP_BSR:  go = 1'b1;
         OP_BT:   go = req.t_flag;
         OP_BF:   go = ~req.t_flag;
         default: go = 1'b0;
      endcase
   end

   // Result assembly
   always_comb begin
      rsp = '0;
      rsp.fault = FAULT_NONE;
      if (has_op) begin
         if (op == OP_BSR) begin
            rsp.lr_write = 1'b1;
            rsp.lr_new   = (req.kind == KIND_BSR4_DISP) ?
                           req.instr_pc + BSR4_LINK_BYTES : req.next_pc;
         end
         if (go) begin
            rsp.taken     = 1'b1;
            rsp.target_pc = dest;
            // null target is an invalid operation
            if (dest == 64'd0) begin
               rsp.fault = FAULT_INVOP;
            end
         end
      end else begin
         case (req.kind)
            KIND_RTS: begin
               rsp.taken     = 1'b1;
               rsp.target_pc = req.lr_value;
            end
            KIND_RET: begin
               rsp.taken     = 1'b1;
               rsp.target_pc = req.stack_word;
               rsp.sp_write  = 1'b1;
               rsp.sp_new    = req.sp_value + SP_POP_BYTES;
            end
            KIND_BREAK: rsp.fault = FAULT_BREAK;
            KIND_SLEEP: rsp.fault = FAULT_SLEEP;
            default:    rsp.fault = FAULT_INVOP;
         endcase
      end
   end

endmodule

>>> src/branch_target_resolver_top.sv
// branch_target_resolver_top: input register, resolve logic, result register.
// Depends on btr_pkg and btr_resolve.
//
//   channel   direction   handshake               payload
//   req       in          req_valid / req_stall   req_data (req_type)
//   rsp       out         rsp_valid / rsp_stall   rsp_data (rsp_type)
//
// One transfer per cycle sustained while rsp is not stalled. A req transfer loads the
// input register; the resolved request then moves into the result register, which
// drives rsp_valid and rsp_data.
// Synchronous active-high reset clears both valid flags.
// rsp_stall holds the result register; the input register keeps accepting
// until both stages are full, so req_stall rises only while rsp is stalled.
module branch_target_resolver_top
   import btr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_data_ff;
   rsp_type resolved;
   logic    out_load;
   logic    in_load;

   // Stage advance control
   assign out_load    = ~out_valid_ff | ~rsp_stall;
   assign req_stall   = in_valid_ff & ~out_load;
   assign in_load     = req_valid & ~req_stall;
   assign in_valid_in = in_load | (in_valid_ff & ~out_load);
   assign out_valid_in = out_load ? in_valid_ff : out_valid_ff;

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_data_ff <= req_data;
      end
   end

   btr_resolve u_resolve (
      .req (in_data_ff),
      .rsp (resolved)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (out_load && in_valid_ff) begin
         out_data_ff <= resolved;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Checks
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a stalled result");

   a_not_taken_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.taken) |-> (rsp_data.target_pc == 64'd0))
      else $error("target_pc nonzero on a not-taken result");

   a_sp_write_taken: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.sp_write) |-> (rsp_data.taken && !rsp_data.lr_write))
      else $error("stack return must be taken and not link");

   a_held_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result changed while stalled");

endmodule

>>> tb/btr_result_checker.sv
// btr_result_checker: watches the req and rsp channels of the branch resolver,
// predicts each result from the request and compares it field by field.
// Depends on btr_pkg for the payload types, kind codes and fault codes.
`timescale 1ns / 1ps

module btr_result_checker
   import btr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   output logic [31:0] mismatch_count,
   output logic [31:0] pending_count
);

   rsp_type     predicted_q[$];
   int unsigned errors  = 0;
   int unsigned waiting = 0;

   assign mismatch_count = errors;
   assign pending_count  = waiting;

   // Expected resolution of one control-flow instruction
   function automatic rsp_type resolve_branch(req_type r);
      rsp_type     res;
      logic [63:0] disp2;
      logic [63:0] dest;
      logic [1:0]  op;
      logic        is_branch;
      logic        go;
      res       = '0;
      res.fault = FAULT_NONE;
      disp2     = {{39{r.displacement[23]}}, r.displacement, 1'b0};
      dest      = '0;
      op        = OP_BRA;
      is_branch = 1'b1;
      if (r.kind <= KIND_BSR4_DISP) begin
         dest = r.next_pc + disp2;
         op   = (r.kind == KIND_BSR4_DISP) ? OP_BSR : r.kind[1:0];
      end else if (r.kind <= KIND_BSR_PCREG) begin
         dest = r.next_pc + (r.reg_operand << 1);
         op   = 2'(r.kind - KIND_BRA_PCREG);
      end else if (r.kind <= KIND_BF_PCDR) begin
         dest = r.next_pc + (r.dr_value << 1);
         op   = 2'(r.kind - KIND_BRA_PCDR);
      end else if (r.kind <= KIND_BF_PCDR4) begin
         dest = r.next_pc + (r.dr_value << 5) + disp2;
         op   = 2'(r.kind - KIND_BRA_PCDR4);
      end else if (r.kind <= KIND_BF_REG) begin
         dest = r.reg_operand;
         op   = 2'(r.kind - KIND_BRA_REG);
      end else begin
         is_branch = 1'b0;
         case (r.kind)
            KIND_RTS: begin
               res.taken     = 1'b1;
               res.target_pc = r.lr_value;
            end
            KIND_RET: begin
               res.taken     = 1'b1;
               res.target_pc = r.stack_word;
               res.sp_write  = 1'b1;
               res.sp_new    = r.sp_value + SP_POP_BYTES;
            end
            KIND_BREAK: res.fault = FAULT_BREAK;
            KIND_SLEEP: res.fault = FAULT_SLEEP;
            // INVOP and the unused codes above it
            default:    res.fault = FAULT_INVOP;
         endcase
      end

      if (is_branch) begin
         go = (op == OP_BRA) || (op == OP_BSR) ||
              (op == OP_BT && r.t_flag) || (op == OP_BF && !r.t_flag);
         // link is written even when the target faults
         if (op == OP_BSR) begin
            res.lr_write = 1'b1;
            res.lr_new   = (r.kind == KIND_BSR4_DISP) ? r.instr_pc + BSR4_LINK_BYTES
                                                      : r.next_pc;
         end
         // taken branch to address zero is an invalid operation
         if (go) begin
            res.taken     = 1'b1;
            res.target_pc = dest;
            if (dest == '0) res.fault = FAULT_INVOP;
         end
      end
      return res;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         errors++;
      end
   endtask

   // Retire result transfers against the oldest prediction, then queue new ones
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_q.size() == 0) begin
               $error("result transfer with no prediction pending");
               errors++;
            end else begin
               want = predicted_q.pop_front();
               check_field("taken",     want.taken,     rsp_data.taken);
               check_field("target_pc", want.target_pc, rsp_data.target_pc);
               check_field("lr_write",  want.lr_write,  rsp_data.lr_write);
               check_field("lr_new",    want.lr_new,    rsp_data.lr_new);
               check_field("sp_write",  want.sp_write,  rsp_data.sp_write);
               check_field("sp_new",    want.sp_new,    rsp_data.sp_new);
               check_field("fault",     want.fault,     rsp_data.fault);
            end
         end
         if (req_valid && !req_stall) predicted_q.push_back(resolve_branch(req_data));
         waiting = predicted_q.size();
      end
   end

endmodule

>>> tb/testbench.sv
// testbench: clock, reset and request/stall stimulus for the branch resolver,
// with btr_result_checker beside the DUT. Depends on btr_pkg,
// branch_target_resolver_top and btr_result_checker.
`timescale 1ns / 1ps

module testbench;
   import btr_pkg::*;

   localparam int RANDOM_REQS = 1750;
   localparam int MAX_IDLE    = 16;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic [31:0] mismatch_count;
   logic [31:0] pending_count;

   int unsigned reqs_sent  = 0;
   int unsigned zero_aimed = 0;
   logic        send_burst = 1'b0;
   logic        recv_burst = 1'b0;

   branch_target_resolver_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   btr_result_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run limit
   initial begin
      #10_000_000;
      $display("branch_target_resolver_top: mismatch");
      $finish;
   end

   // Operand words lean toward the all-zero and all-one extremes
   function automatic logic [63:0] rand_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic req_type random_req(input logic [4:0] k);
      req_type r;
      r.kind        = k;
      r.instr_pc    = rand_word();
      r.next_pc     = rand_word();
      r.reg_operand = rand_word();
      r.dr_value    = rand_word();
      r.lr_value    = rand_word();
      r.sp_value    = rand_word();
      r.stack_word  = rand_word();
      r.t_flag      = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
         0:       r.displacement = 24'sh800000;
         1:       r.displacement = 24'sh7FFFFF;
         default: r.displacement = 24'($urandom);
      endcase
      return r;
   endfunction

   // Pick the base so that the computed branch target lands on zero
   function automatic req_type aim_at_zero(input req_type r);
      req_type     z;
      logic [63:0] d2;
      z  = r;
      d2 = {{39{r.displacement[23]}}, r.displacement, 1'b0};
      if (r.kind <= KIND_BSR4_DISP)      z.next_pc     = -d2;
      else if (r.kind <= KIND_BSR_PCREG) z.next_pc     = -(r.reg_operand << 1);
      else if (r.kind <= KIND_BF_PCDR)   z.next_pc     = -(r.dr_value << 1);
      else if (r.kind <= KIND_BF_PCDR4)  z.next_pc     = -((r.dr_value << 5) + d2);
      else if (r.kind <= KIND_BF_REG)    z.reg_operand = '0;
      return z;
   endfunction

   // One request transfer; valid stays high across back-to-back items
   task automatic send_req(input req_type r);
      int gap;
      if ($urandom_range(0, 39) == 0) send_burst = ~send_burst;
      gap = send_burst ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      reqs_sent++;
   endtask

   // Result side: stall a random number of cycles before each transfer
   initial begin : result_sink
      int hold;
      rsp_stall <= 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) recv_burst = ~recv_burst;
         hold = recv_burst ? 0 : $urandom_range(0, MAX_IDLE);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : stimulus
      req_type    r;
      logic [4:0] k;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: wrap at the extremes, each form, each condition, zero targets
      r = random_req(KIND_BRA_DISP);  r.displacement = 24'sh7FFFFF; r.next_pc = '1;
      send_req(r);
      r = random_req(KIND_BSR_DISP);  r.displacement = 24'sh800000; r.next_pc = '0;
      send_req(r);
      r = random_req(KIND_BT_DISP);   r.t_flag = 1'b1; send_req(r);
      r = random_req(KIND_BF_DISP);   r.t_flag = 1'b1; send_req(r);
      r = random_req(KIND_BSR4_DISP); r.instr_pc = '1; send_req(r);
      r = random_req(KIND_BRA_PCREG); r.reg_operand = '1; send_req(r);
      r = aim_at_zero(random_req(KIND_BSR_PCREG)); send_req(r);
      r = random_req(KIND_BT_PCDR);   r.t_flag = 1'b0; send_req(r);
      r = random_req(KIND_BF_PCDR);   r.t_flag = 1'b0; r.dr_value = '1; send_req(r);
      r = aim_at_zero(random_req(KIND_BRA_PCDR)); send_req(r);
      r = random_req(KIND_BSR_PCDR);  send_req(r);
      // conditional pc+DR*32 form that goes to zero must still fault
      r = aim_at_zero(random_req(KIND_BF_PCDR4)); r.t_flag = 1'b0; send_req(r);
      r = random_req(KIND_BRA_PCDR4); r.dr_value = '1; r.displacement = 24'sh800000;
      send_req(r);
      r = random_req(KIND_BSR_PCDR4); send_req(r);
      r = random_req(KIND_BT_PCDR4);  r.t_flag = 1'b1; send_req(r);
      r = aim_at_zero(random_req(KIND_BRA_REG)); send_req(r);
      r = random_req(KIND_BSR_REG);   send_req(r);
      r = random_req(KIND_BT_REG);    r.t_flag = 1'b0; send_req(r);
      r = random_req(KIND_BF_REG);    r.t_flag = 1'b0; send_req(r);
      // returns take a zero target without faulting
      r = random_req(KIND_RTS);       r.lr_value = '0; send_req(r);
      r = random_req(KIND_RET);       r.stack_word = '0; r.sp_value = '1; send_req(r);
      r = random_req(KIND_BREAK);     send_req(r);
      r = random_req(KIND_SLEEP);     send_req(r);
      r = random_req(KIND_INVOP);     send_req(r);
      r = random_req(5'd24);          send_req(r);
      r = random_req(5'd31);          send_req(r);

      // Random: mostly defined kinds, some unused codes, some zero targets
      repeat (RANDOM_REQS) begin
         if ($urandom_range(0, 15) == 0) k = 5'($urandom_range(24, 31));
         else                            k = 5'($urandom_range(0, 23));
         r = random_req(k);
         if (k <= KIND_BF_REG && $urandom_range(0, 7) == 0) begin
            r = aim_at_zero(r);
            zero_aimed++;
         end
         send_req(r);
      end
      req_valid <= 1'b0;

      // Drain until the checker has retired every queued prediction
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(posedge clock);

      $display("%0d request transfers over all 32 kind codes, %0d random ones aimed at zero",
               reqs_sent, zero_aimed);
      $display("both channels idled 0..%0d cycles per transfer, with idle-free stretches",
               MAX_IDLE);
      if (mismatch_count == 0) begin
         $display("branch_target_resolver_top: match");
      end else begin
         $display("branch_target_resolver_top: mismatch");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/btr_pkg.sv
src/btr_resolve.sv
src/branch_target_resolver_top.sv
tb/btr_result_checker.sv
tb/testbench.sv
